### hw/rtl/lts_pkg.sv
// lts_pkg: shared constants, status codes and controller/datapath interface types
// for the lower-triangular solver; no dependencies
package lts_pkg;

    // largest system the solution store holds
    localparam int MAX_ROWS = 1024;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W    = ROW_W + 1;

    // fixed field widths
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int ROW_IDX_W = 10;
    localparam int SIZE_W    = 11;
    localparam int FRAC_W    = 16;

    // divider runs one quotient bit per step
    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ZERO_DIAG = 2'd1,
        STATUS_SAT       = 2'd2
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // take an input word
        logic mul;       // product of stored unknown and coefficient
        logic acc;       // saturating accumulate, advance column
        logic num;       // numerator b*2^16 - sum
        logic absval;    // magnitudes and sign of the quotient
        logic div_init;  // load remainder, overflow check
        logic div_step;  // one restoring division step
        logic finish;    // store unknown, load result, advance row
    } lts_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_diag;   // incoming word is a diagonal
        logic mac_ok;    // incoming off-diagonal needs a multiply-accumulate
        logic out_free;  // result register can take a new word
    } lts_stat_t;

endpackage

### hw/rtl/lts_ctrl.sv
// lts_ctrl: sequencing state machine of the lower-triangular solver
// depends on lts_pkg
module lts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lts_pkg::lts_stat_t stat,
    output lts_pkg::lts_cmd_t  cmd
);
    import lts_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_ACC  = 8'b0000_0100,
        ST_NUM  = 8'b0000_1000,
        ST_ABS  = 8'b0001_0000,
        ST_CHK  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (stat.is_diag)
                        state_next = ST_NUM;
                    else if (stat.mac_ok)
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_NUM:
            begin
                cmd.num    = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.absval = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait for the result register to drain
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### hw/rtl/lts_datapath.sv
// lts_datapath: solution store, accumulator, row/column counters, divider
// and result register of the lower-triangular solver; depends on lts_pkg
module lts_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lts_pkg::lts_cmd_t                 cmd,
    output lts_pkg::lts_stat_t                stat,
    input  logic                              cfg_valid,
    input  logic [lts_pkg::SIZE_W-1:0]        system_size,
    input  logic signed [lts_pkg::DATA_W-1:0] coefficient,
    input  logic signed [lts_pkg::DATA_W-1:0] rhs_value,
    input  logic                              is_diagonal,
    input  logic                              new_system,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [lts_pkg::DATA_W-1:0] solution,
    output logic [lts_pkg::ROW_IDX_W-1:0]     row_index,
    output logic [1:0]                        status,
    output logic                              last_row
);
    import lts_pkg::*;

    // solution store
    logic [DATA_W-1:0] store_mem [MAX_ROWS];

    logic [SIZE_W-1:0]        size_reg;
    logic signed [DATA_W-1:0] coef_reg;
    logic signed [DATA_W-1:0] rhs_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [ROW_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic [ACC_W-1:0]         num_reg;
    logic [ACC_W-1:0]         mn_reg;
    logic [DATA_W-1:0]        md_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    logic                     ovf_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [DATA_W-1:0]        quot_reg;

    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_x_reg;
    logic [ROW_IDX_W-1:0]     out_row_reg;
    status_t                  out_status_reg;
    logic                     out_last_reg;

    logic [CNT_W-1:0]         size_eff;
    logic                     last;
    logic [ACC_W:0]           acc_sum;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         rhs_scaled;
    logic [ACC_W:0]           num_diff;
    logic [ACC_W-1:0]         num_next;
    logic [DATA_W:0]          rem_shift;
    logic                     rem_ge;
    logic [DATA_W-1:0]        x_val;
    status_t                  x_status;

    // status toward the controller
    assign stat.is_diag  = is_diagonal;
    assign stat.mac_ok   = !new_system && (col_reg < row_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    // effective system size and last-row flag
    always_comb
    begin
        if (size_reg == '0 || 32'(size_reg) > MAX_ROWS)
            size_eff = CNT_W'(MAX_ROWS);
        else
            size_eff = CNT_W'(size_reg);
        last = ({1'b0, row_reg} + CNT_W'(1)) >= size_eff;
    end

    // saturating accumulate of the registered product
    always_comb
    begin
        acc_sum = {acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg};
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
            acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_next = acc_sum[ACC_W-1:0];
    end

    // saturating numerator b*2^16 - sum
    always_comb
    begin
        rhs_scaled = {{(ACC_W-DATA_W-FRAC_W){rhs_reg[DATA_W-1]}}, rhs_reg, {FRAC_W{1'b0}}};
        num_diff   = {rhs_scaled[ACC_W-1], rhs_scaled} - {acc_reg[ACC_W-1], acc_reg};
        if (num_diff[ACC_W] != num_diff[ACC_W-1])
            num_next = num_diff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            num_next = num_diff[ACC_W-1:0];
    end

    // one restoring division step
    always_comb
    begin
        rem_shift = {rem_reg, mn_reg[ACC_W-1]};
        rem_ge    = rem_shift >= {1'b0, md_reg};
    end

    // clamp quotient and pick status
    always_comb
    begin
        x_val    = quot_reg;
        x_status = STATUS_OK;
        if (zero_reg)
        begin
            x_val    = '0;
            x_status = STATUS_ZERO_DIAG;
        end
        else if (!neg_reg)
        begin
            if (ovf_reg || quot_reg[DATA_W-1])
            begin
                x_val    = {1'b0, {(DATA_W-1){1'b1}}};
                x_status = STATUS_SAT;
            end
        end
        else
        begin
            if (ovf_reg || quot_reg > {1'b1, {(DATA_W-1){1'b0}}})
            begin
                x_val    = {1'b1, {(DATA_W-1){1'b0}}};
                x_status = STATUS_SAT;
            end
            else
                x_val = ~quot_reg + DATA_W'(1);
        end
    end

    // store write at row end, read of the next operand every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            store_mem[row_reg] <= x_val;
        rd_data_reg <= store_mem[col_reg];
    end

    // arithmetic payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            coef_reg <= coefficient;
            rhs_reg  <= rhs_value;
        end
        if (cmd.mul)
            prod_reg <= rd_data_reg * coef_reg;
        if (cmd.num)
            num_reg <= num_next;
        if (cmd.absval)
        begin
            mn_reg   <= num_reg[ACC_W-1] ? (~num_reg + ACC_W'(1)) : num_reg;
            md_reg   <= coef_reg[DATA_W-1] ? (~coef_reg + DATA_W'(1)) : coef_reg;
            neg_reg  <= num_reg[ACC_W-1] ^ coef_reg[DATA_W-1];
            zero_reg <= (coef_reg == '0);
        end
        if (cmd.div_init)
        begin
            // quotient fits 32 bits unless the high half reaches the divisor
            ovf_reg  <= mn_reg[ACC_W-1:DATA_W] >= md_reg;
            rem_reg  <= mn_reg[ACC_W-1:DATA_W];
            mn_reg   <= {mn_reg[DATA_W-1:0], {DATA_W{1'b0}}};
            quot_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? DATA_W'(rem_shift - {1'b0, md_reg}) : rem_shift[DATA_W-1:0];
            mn_reg   <= {mn_reg[ACC_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DATA_W-2:0], rem_ge};
        end
        if (cmd.finish)
        begin
            out_x_reg      <= x_val;
            out_row_reg    <= ROW_IDX_W'(row_reg);
            out_status_reg <= x_status;
            out_last_reg   <= last;
        end
    end

    // configuration, accumulator and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(1024);
            acc_reg  <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
                size_reg <= system_size;
            if (cmd.capture && new_system)
            begin
                acc_reg <= '0;
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.acc)
            begin
                acc_reg <= acc_next;
                col_reg <= col_reg + ROW_W'(1);
            end
            else if (cmd.finish)
            begin
                acc_reg <= '0;
                col_reg <= '0;
                row_reg <= last ? '0 : row_reg + ROW_W'(1);
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign solution  = out_x_reg;
    assign row_index = out_row_reg;
    assign status    = out_status_reg;
    assign last_row  = out_last_reg;

endmodule

### hw/rtl/lower_triangular_solver.sv
// lower_triangular_solver: top level, joins controller and datapath
// depends on lts_pkg, lts_ctrl, lts_datapath
//
// Forward-substitution solver for L x = b in signed Q15.16. Each input word
// carries one coefficient of the current row in column order; the diagonal
// word comes last and carries b. One result word per diagonal: the unknown,
// its row, a status (ok, zero diagonal, saturated) and a last-row flag.
// Words are taken one at a time. An off-diagonal word passes through store
// read, multiply and accumulate; one that needs no product is only captured.
// A diagonal word passes through numerator, magnitude and range-check steps
// and then the divider, which makes one quotient bit per cycle; it waits to
// finish only if the previous result has not been taken. The result
// register lets the next word enter while a result is pending. system_size
// is written through its own port and is taken at any time the port is
// valid; write it only while the block is idle. The solution store is not
// cleared at reset and needs no initialization pass.
module lower_triangular_solver (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lts_pkg::SIZE_W-1:0]        system_size,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [lts_pkg::DATA_W-1:0] coefficient,
    input  logic signed [lts_pkg::DATA_W-1:0] rhs_value,
    input  logic                              is_diagonal,
    input  logic                              new_system,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [lts_pkg::DATA_W-1:0] solution,
    output logic [lts_pkg::ROW_IDX_W-1:0]     row_index,
    output logic [1:0]                        status,
    output logic                              last_row
);
    import lts_pkg::*;

    lts_cmd_t  cmd;
    lts_stat_t stat;
    logic      cfg_write;

    // register port always accepts
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    // sequencer
    lts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and arithmetic
    lts_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_write),
        .system_size (system_size),
        .coefficient (coefficient),
        .rhs_value   (rhs_value),
        .is_diagonal (is_diagonal),
        .new_system  (new_system),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .solution    (solution),
        .row_index   (row_index),
        .status      (status),
        .last_row    (last_row)
    );

endmodule

### hw/rtl/lts_checker.sv
// lts_checker: port-level checks of the lower-triangular solver, bound to the top
// depends on lts_pkg and lower_triangular_solver
module lts_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              is_diagonal,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [lts_pkg::DATA_W-1:0] solution,
    input  logic [1:0]                        status
);
    import lts_pkg::*;

    // a stalled result word holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(solution) && $stable(status))
        else $error("result word changed while stalled");

    // a zero diagonal yields a zero unknown
    a_zero_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_ZERO_DIAG |-> solution == '0)
        else $error("zero diagonal with nonzero solution");

    // a saturated result sits at one of the two limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_SAT |->
            solution == {1'b0, {(DATA_W-1){1'b1}}} || solution == {1'b1, {(DATA_W-1){1'b0}}})
        else $error("saturated status with unclamped solution");

    // a diagonal word blocks the input while its division runs
    a_diag_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_diagonal |=> !in_ready)
        else $error("input ready right after a diagonal word");

endmodule

bind lower_triangular_solver lts_checker u_lts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .is_diagonal (is_diagonal),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .solution    (solution),
    .status      (status)
);
